[hdl/cpfm_pkg.sv]
// Shared types and constants of the mean-centered pixel clamp.
`timescale 1ns / 1ps

package cpfm_pkg;

  // Width of one grayscale pixel.
  localparam int unsigned PixW = 8;

  // Brightest pixel value.
  localparam logic [PixW-1:0] PixMax = 8'hFF;

  // Input word kinds carried on the slave tuser bit.
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeRead = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_EMIT = 4'b1000
  } cpfm_state_e;

endpackage

[hdl/cpfm_div.sv]
// Iterative restoring divider: one quotient bit per cycle on a shared subtractor.
`timescale 1ns / 1ps

module cpfm_div #(
  parameter int unsigned DividendW = 21,
  parameter int unsigned DivisorW  = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DividendW + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [StepW-1:0]     step_q;
  logic [DividendW-1:0] num_q;
  logic [DivisorW-1:0]  den_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  rem_d;
  logic [DivisorW:0]    shifted;
  logic                 take;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_q, num_q[DividendW-1]};
  assign take    = (shifted >= {1'b0, den_q});
  always_comb begin
    if (take) begin
      rem_d = DivisorW'(shifted - {1'b0, den_q});
    end else begin
      rem_d = shifted[DivisorW-1:0];
    end
  end

  // Step counter and handshake flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(DividendW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers; quotient bits fill num_q from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DividendW-2:0], take};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

[hdl/clamp_pixels_around_frame_mean_unit.sv]
// Top level of the mean-centered pixel clamp: frame store, sequencer and output register.
`timescale 1ns / 1ps

// Usage:
// Input words arrive on the s_axis channel. tuser selects the kind: 0 loads the pixel in
// tdata into the frame, 1 requests the next clamped pixel. Loads give no output word.
// Each request gives one word on m_axis: tdata is the pixel, tuser[0] says a pixel was
// returned (0 on an empty frame), tuser[1] says loads were dropped because the frame was
// full, and tlast marks the final pixel of the frame. After it the frame is cleared.
// clamp_span is written through cfg_wr_en_i / cfg_wr_data_i; the user must write it only while
// the block is idle, as the block itself does not enforce this. A request is accepted, read
// from the frame store and clamped into the output register; a request on an empty frame skips
// the store read. The first request of a frame also runs the mean division on the divider
// before the store read, one quotient bit per cycle. A request also waits while the output
// register stays full.
// The output word sits in a register, so a new word is accepted while the last result
// waits; a request that finishes while the receiver stalls holds until the register frees.
// Reset clears the frame, the band and clamp_span; the frame store itself is not cleared.
module clamp_pixels_around_frame_mean_unit
  import cpfm_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: clamp_span.
  input  logic       cfg_wr_en_i,
  input  logic [7:0] cfg_wr_data_i,
  // Input words.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] pixel_in
  input  logic       s_axis_tuser_i,  // [0] mode
  // Output words.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] pixel_out
  output logic [1:0] m_axis_tuser_o,  // [0] valid_res, [1] dropped
  output logic       m_axis_tlast_o
);

  localparam int unsigned CntW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned IdxW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned SumW = CntW + PixW;

  cpfm_state_e     state_q, state_d;
  logic [PixW-1:0] span_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] read_idx_q;
  logic [PixW-1:0] band_low_q;
  logic [PixW-1:0] band_high_q;
  logic            active_q;
  logic            overflow_q;
  logic            empty_q;
  logic [PixW-1:0] rd_data_q;

  logic            out_valid_q;
  logic [PixW-1:0] out_pixel_q;
  logic            out_res_q;
  logic            out_last_q;
  logic            out_drop_q;

  logic [PixW-1:0] frame_mem [MAX_PIXELS];

  logic            in_fire;
  logic            load_fire;
  logic            req_fire;
  logic            full;
  logic            store_we;
  logic            div_start;
  logic            div_done;
  logic [SumW-1:0] div_quo;
  logic            out_free;
  logic            emit_fire;
  logic            is_last;
  logic [PixW-1:0] mean;
  logic [PixW-1:0] half;
  logic [PixW-1:0] low_d;
  logic [PixW-1:0] high_d;
  logic [PixW-1:0] clamped;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign load_fire = in_fire && (s_axis_tuser_i == ModeLoad);
  assign req_fire  = in_fire && (s_axis_tuser_i == ModeRead);
  assign full      = (count_q == CntW'(MAX_PIXELS));
  assign store_we  = load_fire && !active_q && !full;
  assign div_start = req_fire && !active_q && (count_q != '0);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign emit_fire = (state_q == ST_EMIT) && out_free;
  assign is_last   = ((CntW'(read_idx_q) + CntW'(1)) >= count_q);

  // Mean over the loaded pixels, done on the divider.
  cpfm_div #(
    .DividendW(SumW),
    .DivisorW (CntW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Band around the mean, saturated at both ends of the pixel range.
  assign mean = (div_quo > SumW'(PixMax)) ? PixMax : div_quo[PixW-1:0];
  assign half = {1'b0, span_q[PixW-1:1]};
  assign low_d  = (mean <= half) ? '0 : (mean - half);
  assign high_d = (mean >= (PixMax - half)) ? PixMax : (mean + half);

  // Clamp the stored pixel to the latched band.
  always_comb begin
    if (rd_data_q < band_low_q) begin
      clamped = band_low_q;
    end else if (rd_data_q > band_high_q) begin
      clamped = band_high_q;
    end else begin
      clamped = rd_data_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (count_q == '0) begin
            state_d = ST_EMIT;
          end else if (!active_q) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and frame bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      span_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      read_idx_q  <= '0;
      band_low_q  <= '0;
      band_high_q <= '0;
      active_q    <= 1'b0;
      overflow_q  <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        span_q <= cfg_wr_data_i;
      end
      // Loads outside a readout store the pixel, or flag it when the frame is full.
      if (store_we) begin
        sum_q   <= sum_q + SumW'(s_axis_tdata_i);
        count_q <= count_q + CntW'(1);
      end
      if (load_fire && !active_q && full) begin
        overflow_q <= 1'b1;
      end
      if (req_fire) begin
        empty_q <= (count_q == '0);
      end
      // First request of a frame latches the band and starts the readout.
      if ((state_q == ST_DIV) && div_done) begin
        band_low_q  <= low_d;
        band_high_q <= high_d;
        read_idx_q  <= '0;
        active_q    <= 1'b1;
      end
      // Step through the frame; the final pixel clears it.
      if (emit_fire && !empty_q) begin
        if (is_last) begin
          sum_q      <= '0;
          count_q    <= '0;
          read_idx_q <= '0;
          active_q   <= 1'b0;
          overflow_q <= 1'b0;
        end else begin
          read_idx_q <= read_idx_q + IdxW'(1);
        end
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame store: one write port for loads, one registered read port for readout.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      frame_mem[count_q[IdxW-1:0]] <= s_axis_tdata_i;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= frame_mem[read_idx_q];
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      if (empty_q) begin
        out_pixel_q <= '0;
        out_res_q   <= 1'b0;
        out_last_q  <= 1'b0;
        out_drop_q  <= 1'b0;
      end else begin
        out_pixel_q <= clamped;
        out_res_q   <= 1'b1;
        out_last_q  <= is_last;
        out_drop_q  <= overflow_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pixel_q;
  assign m_axis_tuser_o  = {out_drop_q, out_res_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

[hdl/cpfm_checker.sv]
// Port-level checks of the mean-centered pixel clamp, bound to the top level.
`timescale 1ns / 1ps

module cpfm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // No output word is offered once reset has been seen at a clock edge.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output word valid during reset");

  // A stalled output word keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  // A request keeps the block busy for at least the next cycle.
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> !s_axis_tready_o)
    else $error("input accepted right after a readout request");

  // An empty-frame answer carries no pixel, no end mark and no drop flag.
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      (m_axis_tdata_o == 8'h00) && !m_axis_tlast_o && !m_axis_tuser_o[1])
    else $error("empty-frame answer carries data");

endmodule

bind clamp_pixels_around_frame_mean_unit cpfm_checker u_cpfm_checker (.*);

[tb/clamp_result_checker.sv]
// Checker for the pixel clamp: predicts every output word from the input words and compares.
`timescale 1ns / 1ps

module clamp_result_checker
  import cpfm_pkg::*;
#(
  parameter int unsigned MaxPix = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [7:0]        cfg_wr_data_i,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [7:0]        s_axis_tdata_i,
  input  logic              s_axis_tuser_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [7:0]        m_axis_tdata_i,
  input  logic [1:0]        m_axis_tuser_i,
  input  logic              m_axis_tlast_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  localparam int unsigned CntW = $clog2(MaxPix + 1);
  localparam int unsigned IdxW = (MaxPix > 1) ? $clog2(MaxPix) : 1;
  localparam int unsigned SumW = CntW + PixW;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            valid_res;
    logic            dropped;
    logic            last;
  } clamp_word_t;

  // Shadow copy of the frame, its running sum and the readout band.
  logic [PixW-1:0] frame_pix [MaxPix];
  logic [SumW-1:0] pix_sum;
  logic [CntW-1:0] n_loaded;
  logic [CntW-1:0] rd_idx;
  logic [PixW-1:0] band_lo;
  logic [PixW-1:0] band_hi;
  logic            reading;
  logic            overflow;
  logic [7:0]      span;

  clamp_word_t     clamped_due[$];
  int unsigned     fail_cnt;
  int unsigned     seen_cnt;

  function automatic void clear_frame();
    pix_sum  = '0;
    n_loaded = '0;
    rd_idx   = '0;
    reading  = 1'b0;
    overflow = 1'b0;
  endfunction

  // Truncated mean with half the span on each side, kept inside the pixel range.
  function automatic void latch_band();
    int unsigned avg;
    int unsigned half;
    avg  = 32'(pix_sum / SumW'(n_loaded));
    half = 32'(span >> 1);
    if (avg > 32'(PixMax)) avg = 32'(PixMax);
    band_lo = (avg <= half) ? 8'd0 : 8'(avg - half);
    band_hi = (avg >= 32'(PixMax) - half) ? PixMax : 8'(avg + half);
  endfunction

  // Applies one accepted input word and queues the output word it should cause.
  function automatic void take_frame_word(logic kind, logic [PixW-1:0] pix);
    logic [PixW-1:0] v;
    logic            fin;
    if (kind == ModeLoad) begin
      if (reading) return;
      if (n_loaded >= CntW'(MaxPix)) begin
        overflow = 1'b1;
        return;
      end
      frame_pix[n_loaded[IdxW-1:0]] = pix;
      pix_sum  = pix_sum + SumW'(pix);
      n_loaded = n_loaded + CntW'(1);
      return;
    end
    // An empty frame answers with an invalid word and leaves everything as it was.
    if (n_loaded == '0) begin
      clamped_due.push_back('{pixel: '0, valid_res: 1'b0, dropped: 1'b0, last: 1'b0});
      return;
    end
    if (!reading) begin
      latch_band();
      rd_idx  = '0;
      reading = 1'b1;
    end
    v = frame_pix[rd_idx[IdxW-1:0]];
    if (v < band_lo) v = band_lo;
    else if (v > band_hi) v = band_hi;
    fin = (rd_idx + CntW'(1) >= n_loaded);
    clamped_due.push_back('{pixel: v, valid_res: 1'b1, dropped: overflow, last: fin});
    if (fin) clear_frame();
    else rd_idx = rd_idx + CntW'(1);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Compares one accepted output word with the oldest prediction.
  function automatic void check_out_word();
    clamp_word_t want;
    if (clamped_due.size() == 0) begin
      $error("output word with no request waiting: pixel_out %0d", m_axis_tdata_i);
      fail_cnt++;
      return;
    end
    want = clamped_due.pop_front();
    seen_cnt++;
    check_field("pixel_out", 32'(want.pixel), 32'(m_axis_tdata_i));
    check_field("valid_res", 32'(want.valid_res), 32'(m_axis_tuser_i[0]));
    check_field("dropped", 32'(want.dropped), 32'(m_axis_tuser_i[1]));
    check_field("last", 32'(want.last), 32'(m_axis_tlast_i));
  endfunction

  // Output words are handled before input words of the same edge, since no
  // request can be answered at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      band_lo  = '0;
      band_hi  = '0;
      span     = '0;
      fail_cnt = 0;
      seen_cnt = 0;
      clamped_due.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_out_word();
      if (cfg_wr_en_i) span = cfg_wr_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) take_frame_word(s_axis_tuser_i, s_axis_tdata_i);
    end
    fail_count_o <= fail_cnt;
    pending_o    <= clamped_due.size();
    checked_o    <= seen_cnt;
  end

endmodule

[tb/testbench.sv]
// Testbench top for the pixel clamp: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import cpfm_pkg::*;

  localparam int unsigned FramePixels  = 4096;
  localparam int unsigned RandomItems  = 1900;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 8_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [7:0]  cfg_wr_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = ModeLoad;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned frames = 0;
  int unsigned span_writes = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  clamp_pixels_around_frame_mean_unit #(.MAX_PIXELS(FramePixels)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  clamp_result_checker #(.MaxPix(FramePixels)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r < 16) return 0;
    if (r < 30) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_span();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver side: random stalls unless the current stretch runs steady.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len();
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Offers one input word after a random gap and waits for its acceptance.
  task automatic send_word(input logic kind, input logic [7:0] pix);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pix;
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_sent++;
  endtask

  // Holds the sender until every predicted word has come out, then lets the block settle.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic retune_span(input logic [7:0] value);
    drain_results();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    span_writes++;
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned len;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty frame, reset span of zero, ignored load during readout.
    send_word(ModeRead, 8'hA5);
    send_word(ModeLoad, 8'h00);
    send_word(ModeLoad, 8'hFF);
    send_word(ModeLoad, 8'h80);
    send_word(ModeRead, 8'h00);
    send_word(ModeLoad, 8'h55);
    send_word(ModeRead, 8'hFF);
    send_word(ModeRead, 8'h00);
    send_word(ModeRead, 8'h3C);
    frames++;

    // Widest band, floored at zero on a frame of one black and one white pixel.
    retune_span(8'd255);
    send_word(ModeLoad, 8'h00);
    send_word(ModeLoad, 8'hFF);
    send_word(ModeRead, 8'h00);
    send_word(ModeRead, 8'h00);
    frames++;

    // Single pixel frame, last on the first word.
    retune_span(8'd1);
    send_word(ModeLoad, 8'd200);
    send_word(ModeRead, 8'hFF);
    frames++;

    // Bright frame capped at the top; the span changes mid-readout and must not matter.
    retune_span(8'd255);
    send_word(ModeLoad, 8'hFF);
    send_word(ModeLoad, 8'hFF);
    send_word(ModeLoad, 8'd10);
    send_word(ModeRead, 8'h00);
    retune_span(8'd0);
    send_word(ModeRead, 8'h00);
    send_word(ModeRead, 8'h00);
    frames++;

    // Random frames of varying size with empty requests, ignored loads and span changes.
    rand_items = 0;
    while (rand_items < RandomItems) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) retune_span(pick_span());
      if ($urandom_range(0, 5) == 0) begin
        send_word(ModeRead, 8'($urandom_range(0, 255)));
        rand_items++;
      end
      case ($urandom_range(0, 9))
        0: len = 1;
        1: len = $urandom_range(25, 200);
        default: len = $urandom_range(2, 24);
      endcase
      for (int unsigned i = 0; i < len; i++) send_word(ModeLoad, rand_pixel());
      for (int unsigned i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 7) == 0) send_word(ModeLoad, rand_pixel());
        if (i > 0 && $urandom_range(0, 29) == 0) retune_span(pick_span());
        send_word(ModeRead, 8'($urandom_range(0, 255)));
      end
      rand_items += 2 * len;
      frames++;
    end

    steady = 1'b0;
    drain_results();

    $display("Sent %0d input words over %0d frames, with empty-frame requests and loads",
             words_sent, frames);
    $display("ignored during readout, %0d span writes; %0d output words were compared.",
             span_writes, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
